// File: hdl/trb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_pkg
// Shared widths, field offsets, CORDIC arctangent table and stage payload
// types of the transformed rectangle bounds engine.
// ----------------------------------------------------------------------------
package trb_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int COORD_BITS   = 24;

	localparam int TAB_W  = 5;
	localparam int XW     = 34;
	localparam int ZW     = 34;
	localparam int CW     = 24;
	localparam int DW     = COORD_BITS + 2;
	localparam int SW     = DW + 8;
	localparam int PW     = CW + SW;
	localparam int OW     = COORD_BITS + 16;
	localparam int FW     = COORD_BITS + 1;

	localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

	localparam int RX_LO = 0;
	localparam int RY_LO = RX_LO + COORD_BITS;
	localparam int RW_LO = RY_LO + COORD_BITS;
	localparam int RH_LO = RW_LO + COORD_BITS - 1;
	localparam int PX_LO = RH_LO + COORD_BITS - 1;
	localparam int PY_LO = PX_LO + COORD_BITS;
	localparam int AN_LO = PY_LO + COORD_BITS;
	localparam int KX_LO = AN_LO + 16;
	localparam int KY_LO = KX_LO + 16;
	localparam int TX_LO = KY_LO + 16;
	localparam int TY_LO = TX_LO + COORD_BITS;
	localparam int IN_BITS  = TY_LO + COORD_BITS;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 4 * COORD_BITS;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam int LAT = CORDIC_STEPS + 6;

	typedef struct packed {
		logic signed [3:0][SW-1:0] sx;
		logic signed [3:0][SW-1:0] sy;
		logic signed [FW-1:0]      offx;
		logic signed [FW-1:0]      offy;
		logic        [1:0]         q;
	} geo_t;

	function automatic logic [31:0] atan_units(input logic [TAB_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10680862;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/trb_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_cordic_cell
// One registered CORDIC rotation step; carries the request payload along.
// ----------------------------------------------------------------------------
module trb_cordic_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [trb_pkg::TAB_W-1:0]         shamt,
	input  logic                              vld_in,
	input  logic signed [trb_pkg::XW-1:0]     x_in,
	input  logic signed [trb_pkg::XW-1:0]     y_in,
	input  logic signed [trb_pkg::ZW-1:0]     z_in,
	input  trb_pkg::geo_t                     geo_in,
	output logic                              vld_q,
	output logic signed [trb_pkg::XW-1:0]     x_q,
	output logic signed [trb_pkg::XW-1:0]     y_q,
	output logic signed [trb_pkg::ZW-1:0]     z_q,
	output trb_pkg::geo_t                     geo_q
);

	logic signed [trb_pkg::XW-1:0] xs, ys;
	logic signed [trb_pkg::ZW-1:0] at;

	always_comb begin
		xs = x_in >>> shamt;
		ys = y_in >>> shamt;
		at = signed'({2'b00, trb_pkg::atan_units(shamt)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_q <= geo_in;
			if (!z_in[trb_pkg::ZW-1]) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - at;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + at;
			end
		end
	end

endmodule

// File: hdl/trb_corner_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_corner_lane
// Rotate one scaled corner offset and add pivot plus translation; two stages.
// ----------------------------------------------------------------------------
module trb_corner_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [trb_pkg::CW-1:0]     cs,
	input  logic signed [trb_pkg::CW-1:0]     sn,
	input  logic signed [trb_pkg::SW-1:0]     sx,
	input  logic signed [trb_pkg::SW-1:0]     sy,
	input  logic signed [trb_pkg::FW-1:0]     offx,
	input  logic signed [trb_pkg::FW-1:0]     offy,
	output logic signed [trb_pkg::OW-1:0]     ox_s2,
	output logic signed [trb_pkg::OW-1:0]     oy_s2
);

	logic signed [trb_pkg::PW-1:0] cx_s1, sy_s1, sx_s1, cy_s1;
	logic signed [trb_pkg::FW-1:0] offx_s1, offy_s1;
	logic signed [trb_pkg::PW:0]   ax, ay, rx, ry;

	always_comb begin
		ax = (trb_pkg::PW+1)'(cx_s1) - (trb_pkg::PW+1)'(sy_s1)
			+ (trb_pkg::PW+1)'(1 << 19);
		ay = (trb_pkg::PW+1)'(sx_s1) + (trb_pkg::PW+1)'(cy_s1)
			+ (trb_pkg::PW+1)'(1 << 19);
		rx = ax >>> 20;
		ry = ay >>> 20;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1   <= trb_pkg::PW'(cs * sx);
			sy_s1   <= trb_pkg::PW'(sn * sy);
			sx_s1   <= trb_pkg::PW'(sn * sx);
			cy_s1   <= trb_pkg::PW'(cs * sy);
			offx_s1 <= offx;
			offy_s1 <= offy;
			ox_s2   <= signed'(rx[trb_pkg::OW-1:0]) + trb_pkg::OW'(offx_s1);
			oy_s2   <= signed'(ry[trb_pkg::OW-1:0]) + trb_pkg::OW'(offy_s1);
		end
	end

endmodule

// File: hdl/transformed_rect_bounds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transformed_rect_bounds
// Bounding box of a rectangle scaled and rotated about a pivot, then shifted.
// ----------------------------------------------------------------------------
// Usage:
//   One request on s_axis carries rectangle, pivot, angle, scale and shift;
//   one result on m_axis carries box position and size, saturated.
//   The pipeline is a prep stage, a chain of CORDIC_STEPS rotation cells,
//   a trig stage, two rotation stages per corner lane, a min/max stage and
//   the output register. Throughput is one request per cycle; every
//   stage advances together. When the receiver stalls with a result
//   pending, the whole pipeline holds and s_axis_tready drops; the output
//   register keeps its result. Reset clears all stage valid flags; the
//   pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module transformed_rect_bounds (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// rect_x, rect_y, rect_w, rect_h, pivot_x, pivot_y, angle, scale_x,
	// scale_y, shift_x, shift_y (lowest first), zero padded
	input  logic [trb_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// box_x, box_y, box_w, box_h (lowest first)
	output logic [trb_pkg::OUT_W-1:0]     m_axis_tdata
);

	localparam int N  = trb_pkg::CORDIC_STEPS;
	localparam int CB = trb_pkg::COORD_BITS;

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// prep
	logic signed [CB-1:0] rx, ry, px, py, tx, ty;
	logic        [CB-2:0] rw, rh;
	logic        [15:0]   ang, ang_r;
	logic signed [15:0]   kx, ky, r;
	logic        [1:0]    q;
	logic signed [trb_pkg::DW-1:0]    dx0, dx1, dy0, dy1;
	logic signed [trb_pkg::DW+15:0]   mx0, mx1, my0, my1;
	trb_pkg::geo_t geo_c;

	always_comb begin
		rx  = signed'(s_axis_tdata[trb_pkg::RX_LO +: CB]);
		ry  = signed'(s_axis_tdata[trb_pkg::RY_LO +: CB]);
		rw  = s_axis_tdata[trb_pkg::RW_LO +: CB-1];
		rh  = s_axis_tdata[trb_pkg::RH_LO +: CB-1];
		px  = signed'(s_axis_tdata[trb_pkg::PX_LO +: CB]);
		py  = signed'(s_axis_tdata[trb_pkg::PY_LO +: CB]);
		ang = s_axis_tdata[trb_pkg::AN_LO +: 16];
		kx  = signed'(s_axis_tdata[trb_pkg::KX_LO +: 16]);
		ky  = signed'(s_axis_tdata[trb_pkg::KY_LO +: 16]);
		tx  = signed'(s_axis_tdata[trb_pkg::TX_LO +: CB]);
		ty  = signed'(s_axis_tdata[trb_pkg::TY_LO +: CB]);
		ang_r = ang + 16'd8192;
		q   = ang_r[15:14];
		r   = signed'(ang - {q, 14'd0});
		dx0 = trb_pkg::DW'(rx) - trb_pkg::DW'(px);
		dx1 = trb_pkg::DW'(rx) + signed'(trb_pkg::DW'(rw)) - trb_pkg::DW'(px);
		dy0 = trb_pkg::DW'(ry) - trb_pkg::DW'(py);
		dy1 = trb_pkg::DW'(ry) + signed'(trb_pkg::DW'(rh)) - trb_pkg::DW'(py);
		mx0 = (trb_pkg::DW+16)'(dx0 * kx) + (trb_pkg::DW+16)'(128);
		mx1 = (trb_pkg::DW+16)'(dx1 * kx) + (trb_pkg::DW+16)'(128);
		my0 = (trb_pkg::DW+16)'(dy0 * ky) + (trb_pkg::DW+16)'(128);
		my1 = (trb_pkg::DW+16)'(dy1 * ky) + (trb_pkg::DW+16)'(128);
		geo_c.sx[0] = signed'(mx0[trb_pkg::DW+15:8]);
		geo_c.sx[1] = signed'(mx1[trb_pkg::DW+15:8]);
		geo_c.sx[2] = signed'(mx0[trb_pkg::DW+15:8]);
		geo_c.sx[3] = signed'(mx1[trb_pkg::DW+15:8]);
		geo_c.sy[0] = signed'(my0[trb_pkg::DW+15:8]);
		geo_c.sy[1] = signed'(my0[trb_pkg::DW+15:8]);
		geo_c.sy[2] = signed'(my1[trb_pkg::DW+15:8]);
		geo_c.sy[3] = signed'(my1[trb_pkg::DW+15:8]);
		geo_c.offx  = trb_pkg::FW'(px) + trb_pkg::FW'(tx);
		geo_c.offy  = trb_pkg::FW'(py) + trb_pkg::FW'(ty);
		geo_c.q     = q;
	end

	logic                          vld [0:N];
	logic signed [trb_pkg::XW-1:0] cx  [0:N];
	logic signed [trb_pkg::XW-1:0] cy  [0:N];
	logic signed [trb_pkg::ZW-1:0] cz  [0:N];
	trb_pkg::geo_t                 cg  [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx[0] <= trb_pkg::CORDIC_GAIN;
			cy[0] <= '0;
			cz[0] <= signed'({{(trb_pkg::ZW-32){r[15]}}, r, 16'd0});
			cg[0] <= geo_c;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		trb_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.shamt  (trb_pkg::TAB_W'(i)),
			.vld_in (vld[i]),
			.x_in   (cx[i]),
			.y_in   (cy[i]),
			.z_in   (cz[i]),
			.geo_in (cg[i]),
			.vld_q  (vld[i+1]),
			.x_q    (cx[i+1]),
			.y_q    (cy[i+1]),
			.z_q    (cz[i+1]),
			.geo_q  (cg[i+1])
		);
	end

	// trig
	logic signed [trb_pkg::XW-1:0] xr, yr;
	logic signed [trb_pkg::CW-1:0] cc, ss, cos_c, sin_c;
	logic signed [trb_pkg::CW-1:0] cos_s1, sin_s1;
	trb_pkg::geo_t                 geo_s1;
	logic                          vld_s1, vld_s2, vld_s3, vld_s4;

	always_comb begin
		xr = (cx[N] + trb_pkg::XW'(512)) >>> 10;
		yr = (cy[N] + trb_pkg::XW'(512)) >>> 10;
		cc = signed'(xr[trb_pkg::CW-1:0]);
		ss = signed'(yr[trb_pkg::CW-1:0]);
		case (cg[N].q)
			2'd0:    begin cos_c = cc;  sin_c = ss;  end
			2'd1:    begin cos_c = -ss; sin_c = cc;  end
			2'd2:    begin cos_c = -cc; sin_c = -ss; end
			default: begin cos_c = ss;  sin_c = -cc; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld[N];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			m_axis_tvalid <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1 <= cos_c;
			sin_s1 <= sin_c;
			geo_s1 <= cg[N];
		end
	end

	logic signed [trb_pkg::OW-1:0] ox [0:3];
	logic signed [trb_pkg::OW-1:0] oy [0:3];

	for (genvar k = 0; k < 4; k++) begin : g_lane
		trb_corner_lane u_lane (
			.clk   (clk),
			.en    (en),
			.cs    (cos_s1),
			.sn    (sin_s1),
			.sx    (geo_s1.sx[k]),
			.sy    (geo_s1.sy[k]),
			.offx  (geo_s1.offx),
			.offy  (geo_s1.offy),
			.ox_s2 (ox[k]),
			.oy_s2 (oy[k])
		);
	end

	// min / max tree
	logic signed [trb_pkg::OW-1:0] mnx_a, mnx_b, mxx_a, mxx_b, mny_a, mny_b, mxy_a, mxy_b;
	logic signed [trb_pkg::OW-1:0] minx_s3, maxx_s3, miny_s3, maxy_s3;

	always_comb begin
		mnx_a = (ox[1] < ox[0]) ? ox[1] : ox[0];
		mnx_b = (ox[3] < ox[2]) ? ox[3] : ox[2];
		mxx_a = (ox[1] > ox[0]) ? ox[1] : ox[0];
		mxx_b = (ox[3] > ox[2]) ? ox[3] : ox[2];
		mny_a = (oy[1] < oy[0]) ? oy[1] : oy[0];
		mny_b = (oy[3] < oy[2]) ? oy[3] : oy[2];
		mxy_a = (oy[1] > oy[0]) ? oy[1] : oy[0];
		mxy_b = (oy[3] > oy[2]) ? oy[3] : oy[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			minx_s3 <= (mnx_b < mnx_a) ? mnx_b : mnx_a;
			maxx_s3 <= (mxx_b > mxx_a) ? mxx_b : mxx_a;
			miny_s3 <= (mny_b < mny_a) ? mny_b : mny_a;
			maxy_s3 <= (mxy_b > mxy_a) ? mxy_b : mxy_a;
		end
	end

	// saturate
	localparam logic signed [trb_pkg::OW:0] S_HI = (trb_pkg::OW+1)'((64'sd1 <<< (CB-1)) - 1);
	localparam logic signed [trb_pkg::OW:0] S_LO = -(trb_pkg::OW+1)'(64'sd1 <<< (CB-1));
	localparam logic signed [trb_pkg::OW:0] U_HI = (trb_pkg::OW+1)'((64'sd1 <<< CB) - 1);

	function automatic logic [CB-1:0] sat_s(input logic signed [trb_pkg::OW:0] v);
		logic signed [trb_pkg::OW:0] t;
		t = (v > S_HI) ? S_HI : ((v < S_LO) ? S_LO : v);
		return t[CB-1:0];
	endfunction

	function automatic logic [CB-1:0] sat_u(input logic signed [trb_pkg::OW:0] v);
		logic signed [trb_pkg::OW:0] t;
		t = (v > U_HI) ? U_HI : ((v < 0) ? '0 : v);
		return t[CB-1:0];
	endfunction

	logic signed [trb_pkg::OW:0] wx, wy;
	logic [trb_pkg::OUT_W-1:0]   out_c;

	always_comb begin
		wx = (trb_pkg::OW+1)'(maxx_s3) - (trb_pkg::OW+1)'(minx_s3);
		wy = (trb_pkg::OW+1)'(maxy_s3) - (trb_pkg::OW+1)'(miny_s3);
		out_c = '0;
		out_c[0 +: CB]      = sat_s((trb_pkg::OW+1)'(minx_s3));
		out_c[CB +: CB]     = sat_s((trb_pkg::OW+1)'(miny_s3));
		out_c[2*CB +: CB]   = sat_u(wx);
		out_c[3*CB +: CB]   = sat_u(wy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= out_c;
		end
	end

endmodule

// File: hdl/trb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_checker
// Port-level checks of the transformed rectangle bounds engine.
// ----------------------------------------------------------------------------
module trb_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [trb_pkg::OUT_W-1:0] m_axis_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	a_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result present right after reset");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid})
		&& (!m_axis_tvalid || !$isunknown(m_axis_tdata)))
		else $error("handshake or result carries unknown bits");

endmodule

bind transformed_rect_bounds trb_checker u_trb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives random and corner-case rectangle transform requests into the
// bounding box engine and checks each result against an in-bench predictor.
// ----------------------------------------------------------------------------

class box_scoreboard;
	typedef struct packed {
		logic signed [23:0] bx;
		logic signed [23:0] by;
		logic        [23:0] bw;
		logic        [23:0] bh;
	} box_t;

	box_t pending[$];
	int   errors;
	int   matched;

	static function longint asr(longint v, int s);
		return v >>> s;
	endfunction

	static function longint rnd(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	static function void trig(logic [15:0] a, output longint c, output longint s);
		logic [15:0] rr;
		logic [1:0]  q;
		longint      x, y, z, xs, ys, cc, ss;
		q = 2'((32'(a) + 32'd8192) >> 14);
		rr = a - 16'(q) * 16'd16384;
		z = longint'($signed(rr)) * 65536;
		x = 652032874;
		y = 0;
		for (int i = 0; i < trb_pkg::CORDIC_STEPS; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(trb_pkg::atan_units(5'(i)));
			end else begin
				x += ys; y -= xs; z += longint'(trb_pkg::atan_units(5'(i)));
			end
		end
		cc = rnd(x, 10);
		ss = rnd(y, 10);
		case (q)
			2'd0: begin c = cc; s = ss; end
			2'd1: begin c = -ss; s = cc; end
			2'd2: begin c = -cc; s = -ss; end
			default: begin c = ss; s = -cc; end
		endcase
	endfunction

	static function box_t transform(logic [trb_pkg::IN_W-1:0] d);
		longint rx, ry, rw, rh, px, py, kx, ky, tx, ty, c, s;
		longint cx, cy, sx, sy, ox, oy, minx, maxx, miny, maxy, wd, ht;
		box_t   r;
		rx = longint'($signed(d[trb_pkg::RX_LO +: 24]));
		ry = longint'($signed(d[trb_pkg::RY_LO +: 24]));
		rw = longint'(d[trb_pkg::RW_LO +: 23]);
		rh = longint'(d[trb_pkg::RH_LO +: 23]);
		px = longint'($signed(d[trb_pkg::PX_LO +: 24]));
		py = longint'($signed(d[trb_pkg::PY_LO +: 24]));
		kx = longint'($signed(d[trb_pkg::KX_LO +: 16]));
		ky = longint'($signed(d[trb_pkg::KY_LO +: 16]));
		tx = longint'($signed(d[trb_pkg::TX_LO +: 24]));
		ty = longint'($signed(d[trb_pkg::TY_LO +: 24]));
		trig(d[trb_pkg::AN_LO +: 16], c, s);
		for (int k = 0; k < 4; k++) begin
			cx = rx + (k[0] ? rw : 0);
			cy = ry + (k[1] ? rh : 0);
			sx = rnd((cx - px) * kx, 8);
			sy = rnd((cy - py) * ky, 8);
			ox = rnd(c * sx - s * sy, 20) + px + tx;
			oy = rnd(s * sx + c * sy, 20) + py + ty;
			if (k == 0 || ox < minx) minx = ox;
			if (k == 0 || ox > maxx) maxx = ox;
			if (k == 0 || oy < miny) miny = oy;
			if (k == 0 || oy > maxy) maxy = oy;
		end
		wd = maxx - minx;
		ht = maxy - miny;
		r.bx = 24'(minx > 8388607 ? 8388607 : (minx < -8388608 ? -8388608 : minx));
		r.by = 24'(miny > 8388607 ? 8388607 : (miny < -8388608 ? -8388608 : miny));
		r.bw = 24'(wd > 16777215 ? 16777215 : (wd < 0 ? 0 : wd));
		r.bh = 24'(ht > 16777215 ? 16777215 : (ht < 0 ? 0 : ht));
		return r;
	endfunction

	function void note_request(logic [trb_pkg::IN_W-1:0] d);
		pending.push_back(transform(d));
	endfunction

	function void check_box(logic [trb_pkg::OUT_W-1:0] d);
		box_t e;
		if (pending.size() == 0) begin
			$error("unexpected result %h", d);
			errors++;
			return;
		end
		e = pending.pop_front();
		matched++;
		if (d[23:0] !== e.bx) begin
			$error("box_x expected %h got %h", e.bx, d[23:0]); errors++;
		end
		if (d[47:24] !== e.by) begin
			$error("box_y expected %h got %h", e.by, d[47:24]); errors++;
		end
		if (d[71:48] !== e.bw) begin
			$error("box_w expected %h got %h", e.bw, d[71:48]); errors++;
		end
		if (d[95:72] !== e.bh) begin
			$error("box_h expected %h got %h", e.bh, d[95:72]); errors++;
		end
	endfunction
endclass

module tb_top;

	localparam int WATCHDOG = 20000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [trb_pkg::IN_W-1:0]  s_axis_tdata = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [trb_pkg::OUT_W-1:0] m_axis_tdata;

	box_scoreboard sb = new();
	int send_idle = 0;
	int recv_stall = 0;
	int idle_cnt = 0;
	int sent = 0;

	always #5 clk = ~clk;

	transformed_rect_bounds dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) sb.check_box(m_axis_tdata);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (!s_axis_tvalid && sb.pending.size() == 0))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("watchdog expired");
			$display("** transformed_rect_bounds: FAILED **");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall);

	function automatic logic [trb_pkg::IN_W-1:0] pack_req(logic [23:0] rx,
			logic [23:0] ry, logic [22:0] rw, logic [22:0] rh, logic [23:0] px,
			logic [23:0] py, logic [15:0] an, logic [15:0] kx, logic [15:0] ky,
			logic [23:0] tx, logic [23:0] ty);
		logic [trb_pkg::IN_W-1:0] d;
		d = '0;
		d[trb_pkg::RX_LO +: 24] = rx; d[trb_pkg::RY_LO +: 24] = ry;
		d[trb_pkg::RW_LO +: 23] = rw; d[trb_pkg::RH_LO +: 23] = rh;
		d[trb_pkg::PX_LO +: 24] = px; d[trb_pkg::PY_LO +: 24] = py;
		d[trb_pkg::AN_LO +: 16] = an;
		d[trb_pkg::KX_LO +: 16] = kx; d[trb_pkg::KY_LO +: 16] = ky;
		d[trb_pkg::TX_LO +: 24] = tx; d[trb_pkg::TY_LO +: 24] = ty;
		return d;
	endfunction

	task automatic send_request(logic [trb_pkg::IN_W-1:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($signed(16'($urandom)));
			2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
			default: return 24'($signed(20'($urandom)));
		endcase
	endfunction

	function automatic logic [15:0] rand_scale();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed(10'($urandom)));
			2: return $urandom_range(1) ? 16'h0100 : 16'hff00;
			default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
		endcase
	endfunction

	task automatic send_random();
		send_request(pack_req(rand_coord(), rand_coord(),
			$urandom_range(1) ? 23'($urandom) : 23'($urandom_range(65535)),
			$urandom_range(1) ? 23'($urandom) : 23'($urandom_range(65535)),
			rand_coord(), rand_coord(),
			$urandom_range(3) == 0 ? 16'(16'h2000 * $urandom_range(7)
				+ $urandom_range(2) - 1) : 16'($urandom),
			rand_scale(), rand_scale(), rand_coord(), rand_coord()));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (trb_pkg::LAT + 4) @(negedge clk);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed corners: extremes, zero size and scale, mirror, quadrant edges
		send_request(pack_req(24'h0, 24'h0, 23'h0, 23'h0, 24'h0, 24'h0, 16'h0,
			16'h0100, 16'h0100, 24'h0, 24'h0));
		send_request(pack_req(24'h000a00, 24'h001400, 23'h003200, 23'h001e00,
			24'h0, 24'h0, 16'h0, 16'h0100, 16'h0100, 24'h000100, 24'hffff00));
		send_request(pack_req(24'h7fffff, 24'h7fffff, 23'h7fffff, 23'h7fffff,
			24'h800000, 24'h800000, 16'h4000, 16'h7fff, 16'h7fff, 24'h7fffff,
			24'h7fffff));
		send_request(pack_req(24'h800000, 24'h800000, 23'h7fffff, 23'h7fffff,
			24'h7fffff, 24'h7fffff, 16'hffff, 16'h8000, 16'h8000, 24'h800000,
			24'h800000));
		send_request(pack_req(24'h001000, 24'h002000, 23'h004000, 23'h001000,
			24'h001000, 24'h002000, 16'h2000, 16'h0000, 16'h0100, 24'h0, 24'h0));
		send_request(pack_req(24'h001000, 24'h002000, 23'h004000, 23'h001000,
			24'h003000, 24'h002800, 16'h8000, 16'hff00, 16'hfe80, 24'h0, 24'h0));
		for (int a = 0; a < 8; a++)
			send_request(pack_req(24'hff0000, 24'h010000, 23'h020000, 23'h008000,
				24'h000000, 24'h000000, 16'(a * 16'h2000 + (a[0] ? 16'hffff : 0)),
				16'h0180, 16'hff40, 24'h000080, 24'hffff80));
		send_request(pack_req(24'h0, 24'h0, 23'h1, 23'h1, 24'h0, 24'h0, 16'h1fff,
			16'h0001, 16'hffff, 24'h0, 24'h0));
		send_request(pack_req(24'h0, 24'h0, 23'h1, 23'h1, 24'h0, 24'h0, 16'h6000,
			16'h0100, 16'h0100, 24'h0, 24'h0));
		drain();
		for (int p = 0; p < 4; p++) begin
			send_idle  = (p == 1 || p == 3) ? (p == 3 ? 8 : 81) : 0;
			recv_stall = (p == 2 || p == 3) ? (p == 3 ? 8 : 81) : 0;
			for (int i = 0; i < 375; i++) send_random();
			drain();
		end
		$display("Covered %0d requests, %0d results checked, across idle and stall phases.",
			sent, sb.matched);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("** transformed_rect_bounds: PASSED **");
		else
			$display("** transformed_rect_bounds: FAILED **");
		$finish;
	end
endmodule
